### src/ritt_pkg.sv
// Shared constants, types and command/status bundles for the radix text unit.
package ritt_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int DIGIT_W         = 4;
    localparam int MAX_DIGITS      = DATA_WIDTH;
    localparam int BITS_PER_STEP   = 4;
    localparam int STEPS_PER_DIGIT = DATA_WIDTH / BITS_PER_STEP;
    localparam int STEP_W          = $clog2(STEPS_PER_DIGIT);
    localparam int CNT_W           = $clog2(MAX_DIGITS + 1);
    localparam int BUF_W           = MAX_DIGITS * DIGIT_W;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 6;
    localparam int RADIX_W         = 5;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
    localparam logic [DIGIT_W-1:0] DEC_MAX = 4'd9;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic digit_end;
        logic emit_sign;
        logic emit_digit;
        logic emit_term;
    } ritt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic neg;
        logic quot_zero;
        logic digits_full;
        logic last_digit;
        logic out_free;
    } ritt_status_t;

endpackage

### src/ritt_ctrl.sv
// Sequencer: digit extraction loop and character emission order.
module ritt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ritt_pkg::ritt_status_t status,
    output ritt_pkg::ritt_cmd_t    cmd
);
    import ritt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_SIGN = 6'b001000,
        ST_DIG  = 6'b010000,
        ST_TERM = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                step_done;

    assign in_stall  = (state_reg != ST_IDLE);
    assign step_done = (step_reg == STEP_W'(STEPS_PER_DIGIT - 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.digit_end = step_done;
                step_next     = step_reg + STEP_W'(1);
                if (step_done)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                step_next = '0;
                if (status.quot_zero || status.digits_full)
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIG;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIG;
                end
            end
            ST_DIG:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM:
            begin
                if (status.out_free)
                begin
                    cmd.emit_term = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.emit_sign, cmd.emit_digit, cmd.emit_term}))
        else $error("ritt_ctrl: overlapping commands");

    a_term_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_term |=> (state_reg == ST_IDLE))
        else $error("ritt_ctrl: terminator not followed by idle");

endmodule

### src/ritt_dp.sv
// Datapath: radix register, magnitude divider, digit stack and output beat register.
module ritt_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [ritt_pkg::RADIX_W-1:0]         cfg_wr_data,
    input  logic signed [ritt_pkg::DATA_WIDTH-1:0] value,
    input  ritt_pkg::ritt_cmd_t                   cmd,
    output ritt_pkg::ritt_status_t                status,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ritt_pkg::CHAR_W-1:0]          char_code,
    output logic [ritt_pkg::LEN_W-1:0]           text_length,
    output logic                                 last
);
    import ritt_pkg::*;

    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    base;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic [DATA_WIDTH-1:0] mag_in;
    logic [DIGIT_W-1:0]    rem_reg;
    logic                  neg_reg;
    logic [BUF_W-1:0]      buf_reg;
    logic [CNT_W-1:0]      ndig_reg;
    logic [CNT_W-1:0]      emit_cnt_reg;
    logic [DATA_WIDTH-1:0] q_next;
    logic [DIGIT_W:0]      r_next;
    logic [DIGIT_W-1:0]    top_digit;
    logic [CHAR_W-1:0]     digit_char;
    logic [LEN_W-1:0]      len_value;
    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  last_reg;
    logic                  emit_any;

    // values 0/1 behave as base 2, values above 16 as base 16
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            base = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            base = RADIX_MAX;
        else
            base = radix_reg;
    end

    assign mag_in = value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;

    // restoring division, BITS_PER_STEP quotient bits per cycle while div_step is set
    always_comb
    begin
        logic [DIGIT_W:0]      r;
        logic [DATA_WIDTH-1:0] q;
        r = {1'b0, rem_reg};
        q = mag_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            r = {r[DIGIT_W-1:0], q[DATA_WIDTH-1]};
            q = {q[DATA_WIDTH-2:0], 1'b0};
            if (r >= base)
            begin
                r    = r - base;
                q[0] = 1'b1;
            end
        end
        r_next = r;
        q_next = q;
    end

    assign top_digit  = buf_reg[BUF_W-1 -: DIGIT_W];
    assign digit_char = (top_digit > DEC_MAX)
                      ? (CH_LOWA + CHAR_W'(top_digit - DIGIT_W'(10)))
                      : (CH_ZERO + CHAR_W'(top_digit));
    assign len_value  = LEN_W'(ndig_reg) + LEN_W'(neg_reg) + LEN_W'(1);
    assign emit_any   = cmd.emit_sign | cmd.emit_digit | cmd.emit_term;

    assign status.neg         = neg_reg;
    assign status.quot_zero   = (mag_reg == '0);
    assign status.digits_full = (ndig_reg == CNT_W'(MAX_DIGITS));
    assign status.last_digit  = ((emit_cnt_reg + CNT_W'(1)) == ndig_reg);
    assign status.out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            ndig_reg      <= '0;
            emit_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                radix_reg <= cfg_wr_data;

            if (cmd.load)
            begin
                rem_reg      <= '0;
                ndig_reg     <= '0;
                emit_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                rem_reg <= cmd.digit_end ? '0 : r_next[DIGIT_W-1:0];
                if (cmd.digit_end)
                    ndig_reg <= ndig_reg + CNT_W'(1);
            end
            else if (cmd.emit_digit)
            begin
                emit_cnt_reg <= emit_cnt_reg + CNT_W'(1);
            end

            if (emit_any)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag_in;
            neg_reg <= value[DATA_WIDTH-1];
        end
        else if (cmd.div_step)
        begin
            mag_reg <= q_next;
            if (cmd.digit_end)
                buf_reg <= {r_next[DIGIT_W-1:0], buf_reg[BUF_W-1:DIGIT_W]};
        end
        else if (cmd.emit_digit)
        begin
            buf_reg <= {buf_reg[BUF_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end

        if (emit_any)
        begin
            len_reg  <= len_value;
            last_reg <= cmd.emit_term;
            if (cmd.emit_sign)
                char_reg <= CH_MINUS;
            else if (cmd.emit_digit)
                char_reg <= digit_char;
            else
                char_reg <= CH_END;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_code   = char_reg;
    assign text_length = len_reg;
    assign last        = last_reg;

    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (char_code == CH_END))
        else $error("ritt_dp: last beat is not the terminator");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ({1'b0, rem_reg} < base))
        else $error("ritt_dp: remainder out of range");

    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= CNT_W'(MAX_DIGITS))
        else $error("ritt_dp: digit count overflow");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !emit_any)
        else $error("ritt_dp: output beat overwritten while stalled");

endmodule

### src/radix_integer_to_text_unit.sv
// Top level of the signed integer to radix text converter.
//
// Input channel: in_valid / in_stall with value (signed 32 bits). A beat is
// taken when in_valid is high and in_stall is low; in_stall is high for the
// whole conversion, so one integer is worked on at a time.
// Output channel: out_valid / out_stall, one beat per character, most
// significant digit first, with a leading '-' for negative input and a zero
// byte (last = 1) at the end. text_length counts all beats incl. terminator.
// Config: cfg_wr_en / cfg_wr_data write the radix (2..16; 0/1 act as 2,
// 17..31 act as 16). Write it only while no conversion is in flight.
// Sequence: a load, then for each digit a run of divider steps at 4 quotient
// bits each and a check, then one character per cycle while the receiver does
// not stall. The slowest case is base 2 with 32 digits and a negative value;
// a single shared divider serves every digit.
// Reset: radix returns to 10, the output register empties, the sequencer
// goes idle. A stalled receiver holds the current beat; the sequencer
// simply waits until the output register frees up.
module radix_integer_to_text_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [ritt_pkg::RADIX_W-1:0]           cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ritt_pkg::DATA_WIDTH-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ritt_pkg::CHAR_W-1:0]            char_code,
    output logic [ritt_pkg::LEN_W-1:0]             text_length,
    output logic                                   last
);
    import ritt_pkg::*;

    ritt_cmd_t    cmd;
    ritt_status_t status;

    // sequencer: load, divide loop, sign/digit/terminator emission
    ritt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // radix register, divider, digit stack, output beat register
    ritt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .text_length (text_length),
        .last        (last)
    );

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> in_stall)
        else $error("radix_integer_to_text_unit: input open during divide");

endmodule
